FILE: design/brl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line rasterizer.
// No dependencies; every other design file refers to this package by scoped names.
package brl_pkg;

   localparam int COORD_W     = 6;
   localparam int ERR_W       = 9;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef logic [COORD_W-1:0]     coord_type;
   typedef logic signed [ERR_W-1:0] err_type;
   typedef logic [QUEUE_PTR_W-1:0] qptr_type;
   typedef logic [QUEUE_CNT_W-1:0] qcnt_type;

   typedef struct packed {
      coord_type col;
      coord_type row;
      coord_type col_end;
      coord_type row_end;
      coord_type dx;
      coord_type dy;
      logic      col_down;
      logic      row_down;
      err_type   err;
   } line_cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

endpackage

FILE: design/brl_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for line commands and plotted pixels.
// Depends on brl_pkg for the coordinate type.
interface brl_req_if;
   logic              valid;
   logic              ready;
   brl_pkg::coord_type start_col;
   brl_pkg::coord_type start_row;
   brl_pkg::coord_type end_col;
   brl_pkg::coord_type end_row;

   modport source (output valid, start_col, start_row, end_col, end_row, input ready);
   modport sink   (input valid, start_col, start_row, end_col, end_row, output ready);
endinterface

interface brl_rsp_if;
   logic              valid;
   logic              ready;
   brl_pkg::coord_type pixel_col;
   brl_pkg::coord_type pixel_row;
   logic              last_pixel;

   modport source (output valid, pixel_col, pixel_row, last_pixel, input ready);
   modport sink   (input valid, pixel_col, pixel_row, last_pixel, output ready);
endinterface

FILE: design/brl_front.sv
`timescale 1ns / 1ps
// Front end: accepts line commands, clamps endpoints and derives deltas, step signs
// and the initial error term. Depends on brl_pkg and brl_req_if.
module brl_front #(
   parameter int CANVAS_SPAN = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   brl_req_if.sink               req_bus,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output brl_pkg::line_cmd_type cmd_data
);

   localparam brl_pkg::coord_type MaxCoord = brl_pkg::COORD_W'(CANVAS_SPAN - 1);

   logic                  valid_ff;
   logic                  valid_in;
   brl_pkg::line_cmd_type cmd_ff;
   brl_pkg::line_cmd_type cmd_in;
   brl_pkg::coord_type    c0;
   brl_pkg::coord_type    r0;
   brl_pkg::coord_type    c1;
   brl_pkg::coord_type    r1;
   logic                  take;

   assign req_bus.ready = !valid_ff || cmd_ready;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      c0 = (req_bus.start_col > MaxCoord) ? MaxCoord : req_bus.start_col;
      r0 = (req_bus.start_row > MaxCoord) ? MaxCoord : req_bus.start_row;
      c1 = (req_bus.end_col > MaxCoord) ? MaxCoord : req_bus.end_col;
      r1 = (req_bus.end_row > MaxCoord) ? MaxCoord : req_bus.end_row;
      cmd_in.col      = c0;
      cmd_in.row      = r0;
      cmd_in.col_end  = c1;
      cmd_in.row_end  = r1;
      cmd_in.dx       = (c0 > c1) ? (c0 - c1) : (c1 - c0);
      cmd_in.dy       = (r0 > r1) ? (r0 - r1) : (r1 - r0);
      cmd_in.col_down = !(c0 < c1);
      cmd_in.row_down = !(r0 < r1);
      cmd_in.err      = $signed({3'b000, cmd_in.dx}) - $signed({3'b000, cmd_in.dy});
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

endmodule

FILE: design/brl_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the pixel stepper.
// Depends on brl_pkg for the command type and queue sizing.
module brl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  brl_pkg::line_cmd_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output brl_pkg::line_cmd_type pop_data
);

   brl_pkg::line_cmd_type mem_ff [brl_pkg::QUEUE_DEPTH];
   brl_pkg::qptr_type     wr_ptr_ff;
   brl_pkg::qptr_type     wr_ptr_in;
   brl_pkg::qptr_type     rd_ptr_ff;
   brl_pkg::qptr_type     rd_ptr_in;
   brl_pkg::qcnt_type     count_ff;
   brl_pkg::qcnt_type     count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != brl_pkg::QUEUE_CNT_W'(brl_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + brl_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - brl_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/brl_stepper.sv
`timescale 1ns / 1ps
// Back end: walks one line with the Bresenham error rule, one pixel per beat.
// Depends on brl_pkg and brl_rsp_if.
module brl_stepper (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  brl_pkg::line_cmd_type cmd_data,
   brl_rsp_if.source             rsp_bus
);

   brl_pkg::back_state_type state_ff;
   brl_pkg::back_state_type state_in;
   brl_pkg::line_cmd_type   cur_ff;
   brl_pkg::line_cmd_type   cur_in;
   logic                    done;
   logic                    fire;
   logic                    load;
   logic signed [9:0]       e2;
   logic                    step_c;
   logic                    step_r;
   brl_pkg::err_type        err_step;

   assign done = (cur_ff.col == cur_ff.col_end) && (cur_ff.row == cur_ff.row_end);
   assign fire = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brl_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               state_in = brl_pkg::BK_RUN;
            end
         end
         brl_pkg::BK_RUN: begin
            if (fire && done && !cmd_valid) begin
               state_in = brl_pkg::BK_IDLE;
            end
         end
         default: state_in = brl_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      rsp_bus.valid = 1'b0;
      load          = 1'b0;
      unique case (state_ff)
         brl_pkg::BK_IDLE: load = cmd_valid;
         brl_pkg::BK_RUN: begin
            rsp_bus.valid = 1'b1;
            load          = cmd_valid && fire && done;
         end
         default: load = 1'b0;
      endcase
   end

   assign cmd_ready = load;

   always_comb begin
      e2       = {cur_ff.err, 1'b0};
      step_c   = e2 > -$signed({4'b0000, cur_ff.dy});
      step_r   = e2 < $signed({4'b0000, cur_ff.dx});
      err_step = cur_ff.err
               - (step_c ? $signed({3'b000, cur_ff.dy}) : 9'sd0)
               + (step_r ? $signed({3'b000, cur_ff.dx}) : 9'sd0);
      cur_in   = cur_ff;
      if (load) begin
         cur_in = cmd_data;
      end else if (fire) begin
         cur_in.err = err_step;
         if (step_c) begin
            cur_in.col = cur_ff.col_down ? cur_ff.col - brl_pkg::COORD_W'(1)
                                         : cur_ff.col + brl_pkg::COORD_W'(1);
         end
         if (step_r) begin
            cur_in.row = cur_ff.row_down ? cur_ff.row - brl_pkg::COORD_W'(1)
                                         : cur_ff.row + brl_pkg::COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brl_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_bus.pixel_col  = cur_ff.col;
   assign rsp_bus.pixel_row  = cur_ff.row;
   assign rsp_bus.last_pixel = done;

endmodule

FILE: design/bresenham_line_rasterizer_core.sv
`timescale 1ns / 1ps
// Bresenham line rasterizer: a line of N = max(|dx|, |dy|) + 1 pixels gives N beats,
// one pixel per cycle from the stepper while the output is ready, the last one flagged.
// A command passes the front register and the queue before the stepper shows its first pixel;
// later commands wait in a two-entry queue and follow the previous end pixel with no idle cycle.
// Synchronous active-high reset empties the front register and queue and idles the stepper.
module bresenham_line_rasterizer_core #(
   parameter int CANVAS_SPAN = 64
) (
   input  logic      clock,
   input  logic      reset,
   brl_req_if.sink   req_bus,
   brl_rsp_if.source rsp_bus
);

   logic                  f_valid;
   logic                  f_ready;
   brl_pkg::line_cmd_type f_data;
   logic                  q_valid;
   logic                  q_ready;
   brl_pkg::line_cmd_type q_data;

   brl_front #(
      .CANVAS_SPAN(CANVAS_SPAN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cmd_valid(f_valid),
      .cmd_ready(f_ready),
      .cmd_data (f_data)
   );

   brl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_data (f_data),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_data  (q_data)
   );

   brl_stepper u_stepper (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(q_valid),
      .cmd_ready(q_ready),
      .cmd_data (q_data),
      .rsp_bus  (rsp_bus)
   );

   a_no_gap_in_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_pixel) |=> rsp_bus.valid)
      else $error("line output stopped before its last pixel");

   a_col_adjacent: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_pixel) |=>
      (rsp_bus.pixel_col == $past(rsp_bus.pixel_col) ||
       rsp_bus.pixel_col == $past(rsp_bus.pixel_col) + 6'd1 ||
       rsp_bus.pixel_col == $past(rsp_bus.pixel_col) - 6'd1))
      else $error("column jumped by more than one between pixels");

   a_row_adjacent: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_pixel) |=>
      (rsp_bus.pixel_row == $past(rsp_bus.pixel_row) ||
       rsp_bus.pixel_row == $past(rsp_bus.pixel_row) + 6'd1 ||
       rsp_bus.pixel_row == $past(rsp_bus.pixel_row) - 6'd1))
      else $error("row jumped by more than one between pixels");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("pixel output valid right after reset");

endmodule

FILE: sim/bresenham_line_rasterizer_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for bresenham_line_rasterizer_core: a directed table of lines, then
// random lines, each pixel beat checked against a built-in line tracer or a typed-in fixed beat.
// Depends on brl_pkg, the channel interfaces in brl_channels.sv and the core itself.
module bresenham_line_rasterizer_core_test;

   localparam int SPAN         = 64;
   localparam int RANDOM_LINES = 236;
   localparam int CALM_LINES   = 40;
   localparam int STALL_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 10;
   localparam int TAIL_CYCLES  = 20;

   typedef struct {
      brl_pkg::coord_type col;
      brl_pkg::coord_type row;
      logic               last;
   } pixel_beat_type;

   typedef struct {
      brl_pkg::coord_type sc;
      brl_pkg::coord_type sr;
      brl_pkg::coord_type ec;
      brl_pkg::coord_type er;
      bit                 fixed;
      brl_pkg::coord_type fc;
      brl_pkg::coord_type fr;
   } line_row_type;

   // Rows marked fixed are single-pixel lines whose one beat is typed in here.
   line_row_type directed_lines[24] = '{
      '{ 0,  0,  0,  0, 1,  0,  0},
      '{63, 63, 63, 63, 1, 63, 63},
      '{ 0, 63,  0, 63, 1,  0, 63},
      '{63,  0, 63,  0, 1, 63,  0},
      '{ 0,  0, 63,  0, 0,  0,  0},
      '{63, 63,  0, 63, 0,  0,  0},
      '{ 0,  0,  0, 63, 0,  0,  0},
      '{63, 63, 63,  0, 0,  0,  0},
      '{ 0,  0, 63, 63, 0,  0,  0},
      '{63,  0,  0, 63, 0,  0,  0},
      '{ 0, 63, 63,  0, 0,  0,  0},
      '{63, 63,  0,  0, 0,  0,  0},
      '{10, 10, 40, 20, 0,  0,  0},
      '{10, 10, 20, 40, 0,  0,  0},
      '{40, 20, 10, 10, 0,  0,  0},
      '{20, 40, 10, 10, 0,  0,  0},
      '{10, 40, 40, 30, 0,  0,  0},
      '{40, 10, 10, 20, 0,  0,  0},
      '{30, 10, 20, 40, 0,  0,  0},
      '{20, 40, 30, 10, 0,  0,  0},
      '{ 0,  0,  1, 63, 0,  0,  0},
      '{ 0,  0, 63,  1, 0,  0,  0},
      '{ 5,  5,  6,  5, 0,  0,  0},
      '{42, 21, 42, 22, 0,  0,  0}
   };

   logic clock = 1'b0;
   logic reset;

   brl_req_if req_ch ();
   brl_rsp_if rsp_ch ();

   bresenham_line_rasterizer_core #(
      .CANVAS_SPAN(SPAN)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_ch),
      .rsp_bus(rsp_ch)
   );

   always #2 clock = ~clock;

   pixel_beat_type pending_pixels[$];
   int             mismatches  = 0;
   int             lines_sent  = 0;
   int             pixels_seen = 0;
   int             quiet_cycles = 0;
   bit             calm = 1'b0;

   function automatic void trace_line(input brl_pkg::coord_type sc,
                                      input brl_pkg::coord_type sr,
                                      input brl_pkg::coord_type ec,
                                      input brl_pkg::coord_type er);
      int             col;
      int             row;
      int             col_end;
      int             row_end;
      int             dx;
      int             dy;
      int             step_c;
      int             step_r;
      int             err;
      int             e2;
      bit             done;
      pixel_beat_type px;
      col     = int'(sc);
      row     = int'(sr);
      col_end = int'(ec);
      row_end = int'(er);
      dx      = (col > col_end) ? col - col_end : col_end - col;
      dy      = (row > row_end) ? row - row_end : row_end - row;
      step_c  = (col < col_end) ? 1 : -1;
      step_r  = (row < row_end) ? 1 : -1;
      err     = dx - dy;
      for (int n = 0; n < SPAN; n++) begin
         done    = (col == col_end) && (row == row_end);
         px.col  = brl_pkg::coord_type'(col);
         px.row  = brl_pkg::coord_type'(row);
         px.last = done;
         pending_pixels.push_back(px);
         if (done) break;
         e2 = 2 * err;
         if (e2 > -dy) begin
            err -= dy;
            col += step_c;
         end
         if (e2 < dx) begin
            err += dx;
            row += step_r;
         end
      end
   endfunction

   function automatic brl_pkg::coord_type near_coord(input brl_pkg::coord_type base);
      int c;
      c = int'(base) + int'($urandom_range(0, 14)) - 7;
      return (c < 0) ? brl_pkg::coord_type'(0) :
             (c > SPAN - 1) ? brl_pkg::coord_type'(SPAN - 1) : brl_pkg::coord_type'(c);
   endfunction

   function automatic line_row_type random_line();
      line_row_type r;
      int           pick;
      r    = '{default: '0};
      pick = $urandom_range(0, 9);
      r.sc = brl_pkg::coord_type'($urandom_range(0, SPAN - 1));
      r.sr = brl_pkg::coord_type'($urandom_range(0, SPAN - 1));
      r.ec = brl_pkg::coord_type'($urandom_range(0, SPAN - 1));
      r.er = brl_pkg::coord_type'($urandom_range(0, SPAN - 1));
      if (pick == 0) begin
         r.ec = r.sc;
         r.er = r.sr;
      end else if (pick <= 5) begin
         r.ec = near_coord(r.sc);
         r.er = near_coord(r.sr);
      end else if (pick == 9) begin
         r.sc = $urandom_range(0, 1) ? brl_pkg::coord_type'(SPAN - 1) : brl_pkg::coord_type'(0);
         r.ec = $urandom_range(0, 1) ? brl_pkg::coord_type'(SPAN - 1) : brl_pkg::coord_type'(0);
      end
      return r;
   endfunction

   task automatic send_line(input line_row_type r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.start_col <= r.sc;
      req_ch.start_row <= r.sr;
      req_ch.end_col   <= r.ec;
      req_ch.end_row   <= r.er;
      do @(posedge clock); while (!req_ch.ready);
      if (r.fixed) pending_pixels.push_back('{col: r.fc, row: r.fr, last: 1'b1});
      else trace_line(r.sc, r.sr, r.ec, r.er);
      lines_sent++;
   endtask

   task automatic note_mismatch(input pixel_beat_type want, input bit have_want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         if (have_want)
            $display({"Pixel mismatch at %0t: expected col %0d row %0d last %0b, ",
                      "got col %0d row %0d last %0b"},
                     $realtime, want.col, want.row, want.last,
                     rsp_ch.pixel_col, rsp_ch.pixel_row, rsp_ch.last_pixel);
         else
            $display("Unexpected pixel beat at %0t: col %0d row %0d last %0b",
                     $realtime, rsp_ch.pixel_col, rsp_ch.pixel_row, rsp_ch.last_pixel);
      end
   endtask

   always @(posedge clock) begin : check_pixels
      pixel_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            want = '{default: '0};
            note_mismatch(want, 1'b0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_ch.pixel_col !== want.col || rsp_ch.pixel_row !== want.row ||
                rsp_ch.last_pixel !== want.last)
               note_mismatch(want, 1'b1);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!calm && $urandom_range(0, 1) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.start_col <= '0;
      req_ch.start_row <= '0;
      req_ch.end_col   <= '0;
      req_ch.end_row   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_lines[i]) send_line(directed_lines[i]);
      for (int i = 0; i < RANDOM_LINES; i++) begin
         calm = (i >= RANDOM_LINES - CALM_LINES);
         send_line(random_line());
      end
      req_ch.valid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Rasterized %0d lines (%0d from the directed table) into %0d pixel beats.",
               lines_sent, $size(directed_lines), pixels_seen);
      $display("Mismatched or unexpected beats: %0d.", mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
